@@ hdl/bpfa_pkg.sv @@
// ----------------------------------------------------------------------------
// bpfa_pkg
// Shared sizes, request and status codes, controller states and the
// command/status bundles between the page allocator controller and datapath.
// ----------------------------------------------------------------------------
package bpfa_pkg;

  // map geometry
  localparam int MAP_PAGES  = 65536;
  localparam int PAGE_BYTES = 4096;
  localparam int WORD_BITS  = 64;
  localparam int BIT_W      = $clog2(WORD_BITS);
  localparam int PAGE_SHIFT = $clog2(PAGE_BYTES);
  localparam int MAP_WORDS  = (MAP_PAGES + WORD_BITS - 1) / WORD_BITS;
  localparam int WI_W       = (MAP_WORDS > 1) ? $clog2(MAP_WORDS) : 1;
  localparam int PAGE_W     = $clog2(MAP_PAGES);

  // field widths
  localparam int KIND_W   = 3;
  localparam int ADDR_W   = 28;
  localparam int COUNT_W  = 17;
  localparam int STATUS_W = 2;
  localparam int CNT_W    = 32;

  // range arithmetic width, wide enough for first page + count and for MAP_PAGES
  localparam int FIRST_W  = ADDR_W - PAGE_SHIFT;
  localparam int SPAN_A   = (FIRST_W > COUNT_W) ? FIRST_W : COUNT_W;
  localparam int SPAN_B   = (SPAN_A > PAGE_W + 1) ? SPAN_A : PAGE_W + 1;
  localparam int SPAN_W   = SPAN_B + 1;

  typedef logic [KIND_W-1:0]   kind_t;
  typedef logic [STATUS_W-1:0] status_t;

  // request kinds
  localparam kind_t KIND_FREE      = 3'd0;
  localparam kind_t KIND_LOCK      = 3'd1;
  localparam kind_t KIND_RESERVE   = 3'd2;
  localparam kind_t KIND_UNRESERVE = 3'd3;
  localparam kind_t KIND_ALLOC     = 3'd4;

  // result status codes
  localparam status_t ST_OK        = 2'd0;
  localparam status_t ST_NO_FREE   = 2'd1;
  localparam status_t ST_RANGE_OUT = 2'd2;

  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_SETUP,
    S_RANGE,
    S_SCAN_START,
    S_SCAN,
    S_FINISH
  } state_t;

  // controller to datapath
  typedef struct packed {
    logic clear_wr;
    logic load_req;
    logic setup;
    logic range_wr;
    logic range_done;
    logic scan_issue;
    logic scan_take;
    logic scan_fail;
    logic out_load;
  } cmd_t;

  // datapath to controller
  typedef struct packed {
    logic clr_last;
    logic kind_range;
    logic kind_alloc;
    logic range_empty;
    logic range_last;
    logic found;
    logic chk_last;
    logic out_free;
  } sts_t;

endpackage

@@ hdl/bpfa_ctrl.sv @@
// ----------------------------------------------------------------------------
// bpfa_ctrl
// Sequencer for the page allocator: clearing pass after reset, request
// setup, word-by-word range update, allocate scan and result hand-off.
// ----------------------------------------------------------------------------
module bpfa_ctrl (
  input  logic           clk,
  input  logic           rst,
  input  logic           in_valid,
  output logic           in_ready,
  input  bpfa_pkg::sts_t st,
  output bpfa_pkg::cmd_t cmd
);
  import bpfa_pkg::*;

  state_t state;
  state_t state_next;

  // state register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_CLEAR;
    end else begin
      state <= state_next;
    end
  end

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      S_CLEAR: begin
        if (st.clr_last) state_next = S_IDLE;
      end
      S_IDLE: begin
        if (in_valid) state_next = S_SETUP;
      end
      S_SETUP: begin
        if (st.kind_range) begin
          state_next = S_RANGE;
        end else if (st.kind_alloc) begin
          state_next = S_SCAN_START;
        end else begin
          state_next = S_FINISH;
        end
      end
      S_RANGE: begin
        if (st.range_empty || st.range_last) state_next = S_FINISH;
      end
      S_SCAN_START: begin
        state_next = S_SCAN;
      end
      S_SCAN: begin
        if (st.found || st.chk_last) state_next = S_FINISH;
      end
      S_FINISH: begin
        if (st.out_free) state_next = S_IDLE;
      end
      default: state_next = S_CLEAR;
    endcase
  end

  // outputs
  always_comb begin
    cmd      = '0;
    in_ready = 1'b0;
    unique case (state)
      S_CLEAR: begin
        cmd.clear_wr = 1'b1;
      end
      S_IDLE: begin
        in_ready     = 1'b1;
        cmd.load_req = in_valid;
      end
      S_SETUP: begin
        cmd.setup = 1'b1;
      end
      S_RANGE: begin
        cmd.range_wr   = !st.range_empty;
        cmd.range_done = st.range_empty || st.range_last;
      end
      S_SCAN_START: begin
        cmd.scan_issue = 1'b1;
      end
      S_SCAN: begin
        cmd.scan_take  = st.found;
        cmd.scan_fail  = !st.found && st.chk_last;
        cmd.scan_issue = !st.found && !st.chk_last;
      end
      S_FINISH: begin
        cmd.out_load = st.out_free;
      end
      default: begin
        cmd = '0;
      end
    endcase
  end

endmodule

@@ hdl/bpfa_dpath.sv @@
// ----------------------------------------------------------------------------
// bpfa_dpath
// Page bitmap memory (64-bit words, bit write mask), request registers,
// range mask generation, first-free search, page counters and result stage.
// ----------------------------------------------------------------------------
module bpfa_dpath (
  input  logic                           clk,
  input  logic                           rst,
  input  bpfa_pkg::cmd_t                 cmd,
  output bpfa_pkg::sts_t                 st,
  input  logic [bpfa_pkg::KIND_W-1:0]    kind,
  input  logic [bpfa_pkg::ADDR_W-1:0]    start_address,
  input  logic [bpfa_pkg::COUNT_W-1:0]   page_count,
  output logic                           out_valid,
  input  logic                           out_ready,
  output logic [bpfa_pkg::STATUS_W-1:0]  status,
  output logic [bpfa_pkg::ADDR_W-1:0]    alloc_address,
  output logic [bpfa_pkg::CNT_W-1:0]     usable_pages,
  output logic [bpfa_pkg::CNT_W-1:0]     reserved_pages
);
  import bpfa_pkg::*;

  // bitmap storage, one bit per page, set means used
  logic [WORD_BITS-1:0] mem [MAP_WORDS];
  logic [WORD_BITS-1:0] rdata;

  // request registers
  kind_t               kind_q;
  logic [FIRST_W-1:0]  first_q;
  logic [COUNT_W-1:0]  count_q;
  logic [PAGE_W-1:0]   first_page;
  logic [PAGE_W-1:0]   last_page;
  logic [SPAN_W-1:0]   span_q;
  logic [WI_W-1:0]     wptr;
  logic [WI_W-1:0]     chk_ptr;
  logic [CNT_W-1:0]    usable;
  logic [CNT_W-1:0]    reserved;
  status_t             res_status;
  logic [ADDR_W-1:0]   res_addr;

  // setup arithmetic
  logic [SPAN_W-1:0]   first_ext;
  logic [SPAN_W-1:0]   end_raw;
  logic [SPAN_W-1:0]   end_cl;
  logic [SPAN_W-1:0]   span_next;
  logic [SPAN_W-1:0]   last_ext;
  logic                ovf;

  // range word mask
  logic [WI_W-1:0]     first_word;
  logic [WI_W-1:0]     last_word;
  logic [BIT_W-1:0]    lo_bit;
  logic [BIT_W-1:0]    hi_bit;
  logic [WORD_BITS-1:0] range_mask;
  logic                set_bits;

  // first-free search
  logic [WORD_BITS-1:0] free_bits;
  logic [BIT_W-1:0]     bit_idx;
  logic [WI_W+BIT_W-1:0] alloc_page;
  logic                 in_map;
  logic [ADDR_W-1:0]    alloc_addr;

  // memory port controls
  logic                 wr_en;
  logic [WI_W-1:0]      wr_addr;
  logic [WORD_BITS-1:0] wr_data;
  logic [WORD_BITS-1:0] wr_mask;

  // request decode
  assign st.kind_range  = (kind_q == KIND_FREE) || (kind_q == KIND_LOCK) ||
                          (kind_q == KIND_RESERVE) || (kind_q == KIND_UNRESERVE);
  assign st.kind_alloc  = (kind_q == KIND_ALLOC);
  assign set_bits       = (kind_q == KIND_LOCK) || (kind_q == KIND_RESERVE);

  // clip the range to the map and count the pages inside it
  always_comb begin
    first_ext = SPAN_W'(first_q);
    end_raw   = first_ext + SPAN_W'(count_q);
    end_cl    = (end_raw > SPAN_W'(MAP_PAGES)) ? SPAN_W'(MAP_PAGES) : end_raw;
    span_next = (first_ext < end_cl) ? end_cl - first_ext : '0;
    last_ext  = end_cl - SPAN_W'(1);
    ovf       = (count_q != '0) && (end_raw > SPAN_W'(MAP_PAGES));
  end

  // bit mask of the pages of the range within the current word
  always_comb begin
    first_word = WI_W'(first_page >> BIT_W);
    last_word  = WI_W'(last_page >> BIT_W);
    lo_bit     = (wptr == first_word) ? first_page[BIT_W-1:0] : '0;
    hi_bit     = (wptr == last_word) ? last_page[BIT_W-1:0] : '1;
    range_mask = ({WORD_BITS{1'b1}} << lo_bit) &
                 ({WORD_BITS{1'b1}} >> (BIT_W'(WORD_BITS - 1) - hi_bit));
  end

  // lowest free bit of the word just read
  always_comb begin
    free_bits = ~rdata;
    bit_idx   = '0;
    for (int b = WORD_BITS - 1; b >= 0; b--) begin
      if (free_bits[b]) bit_idx = BIT_W'(b);
    end
    alloc_page = {chk_ptr, bit_idx};
    in_map     = {1'b0, alloc_page} < (WI_W + BIT_W + 1)'(MAP_PAGES);
    alloc_addr = ADDR_W'({alloc_page, {PAGE_SHIFT{1'b0}}});
  end

  // status to controller
  assign st.clr_last    = (wptr == WI_W'(MAP_WORDS - 1));
  assign st.range_empty = (span_q == '0);
  assign st.range_last  = (wptr == last_word);
  assign st.found       = (free_bits != '0) && in_map;
  assign st.chk_last    = (chk_ptr == WI_W'(MAP_WORDS - 1));
  assign st.out_free    = !out_valid || out_ready;

  // write port select
  always_comb begin
    wr_en   = 1'b0;
    wr_addr = wptr;
    wr_data = '0;
    wr_mask = '0;
    priority if (cmd.clear_wr) begin
      wr_en   = 1'b1;
      wr_mask = '1;
    end else if (cmd.range_wr) begin
      wr_en   = 1'b1;
      wr_data = {WORD_BITS{set_bits}};
      wr_mask = range_mask;
    end else if (cmd.scan_take) begin
      wr_en   = 1'b1;
      wr_addr = chk_ptr;
      wr_data = '1;
      wr_mask = WORD_BITS'(1) << bit_idx;
    end
  end

  // bitmap memory, bit-masked write and registered read
  always_ff @(posedge clk) begin
    if (wr_en) begin
      for (int b = 0; b < WORD_BITS; b++) begin
        if (wr_mask[b]) mem[wr_addr][b] <= wr_data[b];
      end
    end
    if (cmd.scan_issue) begin
      rdata <= mem[wptr];
    end
  end

  // request capture and range setup
  always_ff @(posedge clk) begin
    if (cmd.load_req) begin
      kind_q  <= kind;
      first_q <= FIRST_W'(start_address >> PAGE_SHIFT);
      count_q <= page_count;
    end
    if (cmd.setup) begin
      first_page <= PAGE_W'(first_ext);
      last_page  <= PAGE_W'(last_ext);
      span_q     <= span_next;
    end
    if (cmd.scan_issue) begin
      chk_ptr <= wptr;
    end
  end

  // word pointer: clearing pass, range walk and scan reads
  always_ff @(posedge clk) begin
    if (rst) begin
      wptr <= '0;
    end else if (cmd.clear_wr) begin
      wptr <= st.clr_last ? '0 : WI_W'(wptr + 1'b1);
    end else if (cmd.setup) begin
      wptr <= st.kind_alloc ? '0 : WI_W'(first_ext >> BIT_W);
    end else if (cmd.range_wr && !st.range_last) begin
      wptr <= WI_W'(wptr + 1'b1);
    end else if (cmd.scan_issue) begin
      wptr <= WI_W'(wptr + 1'b1);
    end
  end

  // page counters
  always_ff @(posedge clk) begin
    if (rst) begin
      usable   <= '0;
      reserved <= '0;
    end else if (cmd.range_done) begin
      unique case (kind_q)
        KIND_FREE:      usable   <= usable + CNT_W'(span_q);
        KIND_LOCK:      usable   <= usable - CNT_W'(span_q);
        KIND_RESERVE:   reserved <= reserved + CNT_W'(span_q);
        KIND_UNRESERVE: reserved <= reserved - CNT_W'(span_q);
        default: begin
          usable   <= usable;
          reserved <= reserved;
        end
      endcase
    end else if (cmd.scan_take) begin
      usable <= usable - CNT_W'(1);
    end
  end

  // per-request status and address
  always_ff @(posedge clk) begin
    if (cmd.setup) begin
      res_status <= ovf && st.kind_range ? ST_RANGE_OUT : ST_OK;
      res_addr   <= '0;
    end else if (cmd.scan_take) begin
      res_addr <= alloc_addr;
    end else if (cmd.scan_fail) begin
      res_status <= ST_NO_FREE;
    end
  end

  // result stage
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.out_load) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      status         <= res_status;
      alloc_address  <= res_addr;
      usable_pages   <= usable;
      reserved_pages <= reserved;
    end
  end

  // checks
  a_one_writer: assert property (@(posedge clk) disable iff (rst)
    $onehot0({cmd.clear_wr, cmd.range_wr, cmd.scan_take}))
    else $error("more than one bitmap writer active");

  a_take_found: assert property (@(posedge clk) disable iff (rst)
    cmd.scan_take |-> st.found)
    else $error("allocate committed without a free page");

  a_mask_nonzero: assert property (@(posedge clk) disable iff (rst)
    cmd.range_wr |-> (range_mask != '0))
    else $error("range write with empty mask");

  a_addr_zero: assert property (@(posedge clk) disable iff (rst)
    (out_valid && (status != ST_OK)) |-> (alloc_address == '0))
    else $error("failed request carries an address");

endmodule

@@ hdl/bitmap_page_frame_allocator.sv @@
// ----------------------------------------------------------------------------
// bitmap_page_frame_allocator
// First-fit page frame allocator over a one-bit-per-page bitmap. After reset
// a clearing pass, one 64-bit bitmap word per cycle, marks every page free;
// in_ready stays low until it is done. A request is then handled one at a
// time: a range request (free, lock, reserve, unreserve) passes through
// setup and then updates one 64-page bitmap word per cycle over the words
// it touches, none for an empty range; an allocate passes through setup and
// a first read, then reads one bitmap word per cycle up to and including
// the first word with a free page, or to the last word on a full map; an
// unused kind goes from setup straight to the result hand-off. The result
// waits in an output register, and the next request is taken while it
// waits; a request that finishes while the previous result still waits
// holds in its last cycle until that result is taken. Pages past the end of
// the map are skipped and flagged in status; both page counters wrap
// modulo 2^32.
// ----------------------------------------------------------------------------
module bitmap_page_frame_allocator (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           in_valid,
  output logic                           in_ready,
  input  logic [bpfa_pkg::KIND_W-1:0]    kind,
  input  logic [bpfa_pkg::ADDR_W-1:0]    start_address,
  input  logic [bpfa_pkg::COUNT_W-1:0]   page_count,
  output logic                           out_valid,
  input  logic                           out_ready,
  output logic [bpfa_pkg::STATUS_W-1:0]  status,
  output logic [bpfa_pkg::ADDR_W-1:0]    alloc_address,
  output logic [bpfa_pkg::CNT_W-1:0]     usable_pages,
  output logic [bpfa_pkg::CNT_W-1:0]     reserved_pages
);
  import bpfa_pkg::*;

  cmd_t cmd;
  sts_t st;

  // sequencer
  bpfa_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .st       (st),
    .cmd      (cmd)
  );

  // bitmap, counters and result stage
  bpfa_dpath u_dpath (
    .clk            (clk),
    .rst            (rst),
    .cmd            (cmd),
    .st             (st),
    .kind           (kind),
    .start_address  (start_address),
    .page_count     (page_count),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .status         (status),
    .alloc_address  (alloc_address),
    .usable_pages   (usable_pages),
    .reserved_pages (reserved_pages)
  );

endmodule
